// ===== src/ismd_pkg.sv =====
// ----------------------------------------------------------------------------
// ismd_pkg: shared constants and types for the Ising Metropolis step unit
// Grid geometry, field widths, command codes and controller/datapath links.
// ----------------------------------------------------------------------------
package ismd_pkg;

    // Grid geometry
    localparam int GRID_SIZE = 256;
    localparam int IDX_W     = $clog2(GRID_SIZE);

    // Field widths
    localparam int COORD_W   = 8;
    localparam int WEIGHT_W  = 16;
    localparam int SAMPLE_W  = 24;
    localparam int ENERGY_W  = 24;
    localparam int CMD_W     = 2;
    localparam int CFG_IDX_W = 4;

    // Packed stream widths
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 32;

    // Intermediate widths
    localparam int SUM_W  = 5;                    // neighbour sum, -8..+8
    localparam int DATA_W = WEIGHT_W + 1;         // +/- gamma
    localparam int MUL_W  = WEIGHT_W + SUM_W;     // beta * signed sum
    localparam int DIFF_W = ENERGY_W - 1;         // half of deltaE

    // Register reset values
    localparam logic [WEIGHT_W-1:0] COUPLING_RESET = 16'd4096;
    localparam logic [WEIGHT_W-1:0] DATA_RESET     = 16'd4500;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PROPOSE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_SPARE   = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COUPLING = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA     = 4'd1;

    // Row read selection
    localparam logic [1:0] RD_CENTER = 2'd0;
    localparam logic [1:0] RD_UP     = 2'd1;
    localparam logic [1:0] RD_DOWN   = 2'd2;

    // Result kinds
    localparam logic [1:0] RES_ZERO = 2'd0;
    localparam logic [1:0] RES_LOAD = 2'd1;
    localparam logic [1:0] RES_READ = 2'd2;
    localparam logic [1:0] RES_PROP = 2'd3;

    typedef struct packed {
        logic       latch;
        logic       wr_load;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       cap_center;
        logic       cap_up;
        logic       cap_down;
        logic       mul_en;
        logic       res_en;
        logic [1:0] res_kind;
        logic       push;
    } ctrl_cmd_t;

    typedef struct packed {
        logic             in_grid;
        logic [CMD_W-1:0] command;
    } dp_stat_t;

endpackage

// ===== src/ismd_ctrl.sv =====
// ----------------------------------------------------------------------------
// ismd_ctrl: sequencing state machine of the Ising Metropolis step unit
// Steps each transaction through decode, row reads, multiply and evaluate.
// ----------------------------------------------------------------------------
module ismd_ctrl
    import ismd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  dp_stat_t  stat,
    output ctrl_cmd_t cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_CENTER = 3'd2;
    localparam logic [2:0] S_UP     = 3'd3;
    localparam logic [2:0] S_DOWN   = 3'd4;
    localparam logic [2:0] S_MUL    = 3'd5;
    localparam logic [2:0] S_EVAL   = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (!stat.in_grid)
                begin
                    cmd.res_en   = 1'b1;
                    cmd.res_kind = RES_ZERO;
                    state_next   = S_DONE;
                end
                else
                begin
                    case (stat.command) inside
                        CMD_LOAD:
                        begin
                            cmd.wr_load  = 1'b1;
                            cmd.res_en   = 1'b1;
                            cmd.res_kind = RES_LOAD;
                            state_next   = S_DONE;
                        end
                        CMD_PROPOSE, CMD_READ, CMD_SPARE:
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RD_CENTER;
                            state_next = S_CENTER;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_CENTER:
            begin
                cmd.cap_center = 1'b1;
                if (stat.command == CMD_PROPOSE)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_UP;
                    state_next = S_UP;
                end
                else
                begin
                    cmd.res_en   = 1'b1;
                    cmd.res_kind = RES_READ;
                    state_next   = S_DONE;
                end
            end
            S_UP:
            begin
                cmd.cap_up = 1'b1;
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_DOWN;
                state_next = S_DOWN;
            end
            S_DOWN:
            begin
                cmd.cap_down = 1'b1;
                state_next   = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                cmd.res_en   = 1'b1;
                cmd.res_kind = RES_PROP;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.push)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== src/ismd_dp.sv =====
// ----------------------------------------------------------------------------
// ismd_dp: datapath of the Ising Metropolis step unit
// Image stores, window capture, energy arithmetic, weights and result.
// ----------------------------------------------------------------------------
module ismd_dp
    import ismd_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  ctrl_cmd_t                  cmd,
    output dp_stat_t                   stat,
    input  logic                       cfg_wr,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [WEIGHT_W-1:0]        cfg_data,
    input  logic [CMD_W-1:0]           command,
    input  logic [COORD_W-1:0]         row,
    input  logic [COORD_W-1:0]         column,
    input  logic                       pixel_in,
    input  logic signed [SAMPLE_W-1:0] log_sample,
    output logic                       pixel_out,
    output logic                       flipped,
    output logic signed [ENERGY_W-1:0] energy_change
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(GRID_SIZE - 1);

    // image stores: one row of pixels per word, bit written per pixel
    logic [GRID_SIZE-1:0] cur_mem   [GRID_SIZE];
    logic [GRID_SIZE-1:0] noisy_mem [GRID_SIZE];
    logic [GRID_SIZE-1:0] cur_rd_reg;
    logic [GRID_SIZE-1:0] noisy_rd_reg;

    logic signed [WEIGHT_W-1:0] coupling_reg;
    logic signed [WEIGHT_W-1:0] data_weight_reg;

    logic [CMD_W-1:0]           cmd_reg;
    logic [COORD_W-1:0]         row_reg;
    logic [COORD_W-1:0]         col_reg;
    logic                       pix_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;

    logic [2:0]                 up_reg;
    logic [2:0]                 mid_reg;
    logic [2:0]                 dn_reg;
    logic                       noisy_reg;
    logic signed [MUL_W-1:0]    mul_reg;
    logic signed [DATA_W-1:0]   dterm_reg;

    logic                       res_pix_reg;
    logic                       res_flip_reg;
    logic signed [ENERGY_W-1:0] res_energy_reg;
    logic                       out_pix_reg;
    logic                       out_flip_reg;
    logic signed [ENERGY_W-1:0] out_energy_reg;

    logic [IDX_W-1:0]           ridx;
    logic [IDX_W-1:0]           cidx;
    logic [IDX_W-1:0]           row_up;
    logic [IDX_W-1:0]           row_dn;
    logic [IDX_W-1:0]           col_lt;
    logic [IDX_W-1:0]           col_rt;
    logic [IDX_W-1:0]           rd_addr;
    logic [2:0]                 row_ok;
    logic [2:0]                 col_ok;
    logic [2:0]                 win3;
    logic signed [SUM_W-1:0]    nsum;
    logic signed [SUM_W-1:0]    csum;
    logic signed [DATA_W-1:0]   gamma_ext;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [ENERGY_W-1:0] delta_e;
    logic                       accept_flip;
    logic                       cur_wr;
    logic                       cur_wr_bit;

    assign ridx   = IDX_W'(row_reg);
    assign cidx   = IDX_W'(col_reg);
    assign row_up = (ridx == '0) ? ridx : ridx - 1'b1;
    assign row_dn = (ridx == LAST_IDX) ? ridx : ridx + 1'b1;
    assign col_lt = (cidx == '0) ? cidx : cidx - 1'b1;
    assign col_rt = (cidx == LAST_IDX) ? cidx : cidx + 1'b1;

    assign row_ok = {ridx != LAST_IDX, 1'b1, ridx != '0};
    assign col_ok = {cidx != LAST_IDX, 1'b1, cidx != '0};

    assign stat.in_grid = (32'(row_reg) < GRID_SIZE) && (32'(col_reg) < GRID_SIZE);
    assign stat.command = cmd_reg;

    always_comb
    begin
        case (cmd.rd_sel)
            RD_UP:   rd_addr = row_up;
            RD_DOWN: rd_addr = row_dn;
            default: rd_addr = ridx;
        endcase
    end

    // left, centre and right pixels of the row just read
    assign win3 = {cur_rd_reg[col_rt], cur_rd_reg[cidx], cur_rd_reg[col_lt]};

    // sum of spins over the in-grid neighbours
    always_comb
    begin
        logic [2:0] rowbits;
        nsum = '0;
        for (int i = 0; i < 3; i++)
        begin
            rowbits = (i == 0) ? up_reg : ((i == 1) ? mid_reg : dn_reg);
            for (int j = 0; j < 3; j++)
            begin
                if (!(i == 1 && j == 1) && row_ok[i] && col_ok[j])
                begin
                    nsum = rowbits[j] ? nsum + SUM_W'(1) : nsum - SUM_W'(1);
                end
            end
        end
    end

    assign csum      = mid_reg[1] ? nsum : -nsum;
    assign gamma_ext = DATA_W'(data_weight_reg);

    // deltaE = 2 * (dterm - beta * cur * sum)
    assign diff        = DIFF_W'(dterm_reg) - DIFF_W'(mul_reg);
    assign delta_e     = $signed({diff, 1'b0});
    assign accept_flip = (sample_reg <= delta_e);

    assign cur_wr     = cmd.wr_load || (cmd.res_en && (cmd.res_kind == RES_PROP) && accept_flip);
    assign cur_wr_bit = cmd.wr_load ? pix_reg : ~mid_reg[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coupling_reg    <= COUPLING_RESET;
            data_weight_reg <= DATA_RESET;
        end
        else if (cfg_wr)
        begin
            if (cfg_index == CFG_COUPLING)
            begin
                coupling_reg <= cfg_data;
            end
            if (cfg_index == CFG_DATA)
            begin
                data_weight_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cur_wr)
        begin
            cur_mem[ridx][cidx] <= cur_wr_bit;
        end
        if (cmd.wr_load)
        begin
            noisy_mem[ridx][cidx] <= pix_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            cur_rd_reg   <= cur_mem[rd_addr];
            noisy_rd_reg <= noisy_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            cmd_reg    <= command;
            row_reg    <= row;
            col_reg    <= column;
            pix_reg    <= pixel_in;
            sample_reg <= log_sample;
        end
        if (cmd.cap_center)
        begin
            mid_reg   <= win3;
            noisy_reg <= noisy_rd_reg[cidx];
        end
        if (cmd.cap_up)
        begin
            up_reg <= win3;
        end
        if (cmd.cap_down)
        begin
            dn_reg <= win3;
        end
        if (cmd.mul_en)
        begin
            mul_reg   <= coupling_reg * csum;
            dterm_reg <= (noisy_reg == mid_reg[1]) ? -gamma_ext : gamma_ext;
        end
        if (cmd.res_en)
        begin
            case (cmd.res_kind)
                RES_LOAD:
                begin
                    res_pix_reg    <= pix_reg;
                    res_flip_reg   <= 1'b0;
                    res_energy_reg <= '0;
                end
                RES_READ:
                begin
                    res_pix_reg    <= win3[1];
                    res_flip_reg   <= 1'b0;
                    res_energy_reg <= '0;
                end
                RES_PROP:
                begin
                    res_pix_reg    <= mid_reg[1] ^ accept_flip;
                    res_flip_reg   <= accept_flip;
                    res_energy_reg <= delta_e;
                end
                default:
                begin
                    res_pix_reg    <= 1'b0;
                    res_flip_reg   <= 1'b0;
                    res_energy_reg <= '0;
                end
            endcase
        end
        if (cmd.push)
        begin
            out_pix_reg    <= res_pix_reg;
            out_flip_reg   <= res_flip_reg;
            out_energy_reg <= res_energy_reg;
        end
    end

    assign pixel_out     = out_pix_reg;
    assign flipped       = out_flip_reg;
    assign energy_change = out_energy_reg;

endmodule

// ===== src/ising_metropolis_denoise_step_unit.sv =====
// ----------------------------------------------------------------------------
// ising_metropolis_denoise_step_unit: Metropolis step for Ising denoising
// Holds a noisy binary image and its current estimate; loads, reads and
// proposes single-pixel flips against the neighbour and data energies.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one command per transaction: tuser selects load,
//   propose or read, tdata carries row, column, pixel and log sample. Each
//   transaction returns exactly one result transaction on the master stream.
//   The configuration channel writes beta (index 0) and gamma (index 1); it is
//   always ready. The user must write it only while no command is in flight;
//   the block itself does not enforce this.
// Sequencing: one command at a time; the next is taken once the last result is
//   in the output register. A proposal reads the 3x3 window one row per cycle
//   from the single read port of the row-wide image store, then does the beta
//   multiply and then the add and compare with write-back of the flipped pixel.
// Stalls: the result sits in an output register, so the next command is taken
//   while a result waits; a finished result is held in the datapath until the
//   output register frees, and s_axis_tready stays low meanwhile.
// Reset: clears the sequencer and output valid and restores the weights to
//   4096 and 4500. The image stores are not cleared; read pixels only after
//   loading them.
// ----------------------------------------------------------------------------
module ising_metropolis_denoise_step_unit
    import ismd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // slave stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_DATA_W-1:0]   s_axis_tdata,  // row[7:0], column[15:8],
                                                  // pixel_in[16], log_sample[40:17]
    input  logic [CMD_W-1:0]       s_axis_tuser,  // command[1:0]
    // master stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_DATA_W-1:0]  m_axis_tdata,  // pixel_out[0], flipped[1],
                                                  // energy_change[25:2]
    // configuration write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [WEIGHT_W-1:0]    cfg_data
);

    localparam int PIX_LSB    = 2 * COORD_W;
    localparam int SAMPLE_LSB = PIX_LSB + 1;
    localparam int OUT_USED_W = 2 + ENERGY_W;

    ctrl_cmd_t                  cmd;
    dp_stat_t                   stat;
    logic                       pixel_out;
    logic                       flipped;
    logic signed [ENERGY_W-1:0] energy_change;

    // weights are plain registers: take every write at once
    assign cfg_ready = 1'b1;

    ismd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ismd_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_wr        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .command       (s_axis_tuser),
        .row           (s_axis_tdata[COORD_W-1:0]),
        .column        (s_axis_tdata[PIX_LSB-1:COORD_W]),
        .pixel_in      (s_axis_tdata[PIX_LSB]),
        .log_sample    (s_axis_tdata[SAMPLE_LSB+SAMPLE_W-1:SAMPLE_LSB]),
        .pixel_out     (pixel_out),
        .flipped       (flipped),
        .energy_change (energy_change)
    );

    // pack the result, zero the spare top bits
    assign m_axis_tdata = {{(OUT_DATA_W - OUT_USED_W){1'b0}}, energy_change, flipped, pixel_out};

endmodule

// ===== src/ismd_checker.sv =====
// ----------------------------------------------------------------------------
// ismd_checker: port-level checks for the Ising Metropolis step unit
// Watches the stream ports over time; bound to the top.
// ----------------------------------------------------------------------------
module ismd_checker
    import ismd_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

    // one command in flight: drop ready after each accepted transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second command taken while one is in flight");

    // no result can appear in the cycle straight after a command is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result appeared too early");

    // deltaE is twice an integer combination, so its lowest bit is zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !m_axis_tdata[2])
    else $error("odd energy change reported");

endmodule

bind ising_metropolis_denoise_step_unit ismd_checker u_ismd_checker (.*);
